/* sv/bsc_pkg.sv */
`default_nettype none
package bsc_pkg;

  typedef enum logic [3:0] {
    OP_SET_EN     = 4'd0,
    OP_SET_BRIGHT = 4'd1,
    OP_SET_ON     = 4'd2,
    OP_SET_OFF    = 4'd3,
    OP_TOGGLE     = 4'd4,
    OP_INC        = 4'd5,
    OP_DEC        = 4'd6,
    OP_CYC_ON     = 4'd7,
    OP_CYC_OFF    = 4'd8,
    OP_SWITCH     = 4'd9,
    OP_WIFI       = 4'd10,
    OP_REFRESH    = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    UPD_ONOFF  = 3'd0,
    UPD_BRIGHT = 3'd1,
    UPD_SWITCH = 3'd2,
    UPD_WIFI   = 3'd3,
    UPD_COLOR  = 3'd4
  } upd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic       enable_in;
    logic [7:0] brightness_in;
    rgb_t       color_in;
    logic [7:0] switch_index;
    logic       switch_on;
    logic [7:0] wifi_pattern;
  } cmd_t;

  typedef struct packed {
    upd_t       update_type;
    logic [7:0] update_param;
    logic       update_mask;
    logic       enabled_now;
    logic [6:0] brightness_now;
    rgb_t       on_rgb;
    rgb_t       off_rgb;
  } rslt_t;

  localparam logic [6:0] BRIGHT_MAX      = 7'd100;
  localparam logic [6:0] BRIGHT_STEP_TOP = 7'd90;
  localparam logic [6:0] BRIGHT_STEP_LOW = 7'd20;
  localparam logic [6:0] BRIGHT_STEP     = 7'd10;
  localparam logic [6:0] BRIGHT_FLOOR    = 7'd10;

  localparam rgb_t ON_RESET  = '{8'd0, 8'd0, 8'd255};
  localparam rgb_t OFF_RESET = '{8'd128, 8'd128, 8'd128};

  localparam int ON_N  = 10;
  localparam int OFF_N = 9;

  localparam rgb_t ON_PAL [ON_N] = '{
    '{8'd0,   8'd0,   8'd255}, '{8'd0,   8'd255, 8'd0},
    '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd255},
    '{8'd255, 8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},
    '{8'd255, 8'd128, 8'd0},   '{8'd255, 8'd255, 8'd255},
    '{8'd255, 8'd180, 8'd50},  '{8'd128, 8'd0,   8'd255}
  };

  localparam rgb_t OFF_PAL [OFF_N] = '{
    '{8'd128, 8'd128, 8'd128}, '{8'd0,  8'd0,  8'd0},
    '{8'd40,  8'd0,   8'd0},   '{8'd0,  8'd0,  8'd40},
    '{8'd0,   8'd40,  8'd0},   '{8'd40, 8'd20, 8'd0},
    '{8'd30,  8'd30,  8'd30},  '{8'd0,  8'd30, 8'd30},
    '{8'd25,  8'd0,   8'd40}
  };

  // Next on-palette entry; a color not in the palette goes to the first entry.
  function automatic rgb_t on_advance(rgb_t c);
    logic [3:0] idx;
    logic [3:0] nxt;
    logic       hit;
    idx = '0;
    hit = 1'b0;
    for (int k = ON_N - 1; k >= 0; k--) begin
      if (c == ON_PAL[k]) begin
        hit = 1'b1;
        idx = 4'(k);
      end
    end
    if (!hit || idx == 4'(ON_N - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 4'd1;
    end
    return ON_PAL[nxt];
  endfunction

  function automatic rgb_t off_advance(rgb_t c);
    logic [3:0] idx;
    logic [3:0] nxt;
    logic       hit;
    idx = '0;
    hit = 1'b0;
    for (int k = OFF_N - 1; k >= 0; k--) begin
      if (c == OFF_PAL[k]) begin
        hit = 1'b1;
        idx = 4'(k);
      end
    end
    if (!hit || idx == 4'(OFF_N - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 4'd1;
    end
    return OFF_PAL[nxt];
  endfunction

endpackage
`default_nettype wire

/* sv/bsc_in_reg.sv */
`default_nettype none
module bsc_in_reg
  import bsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cmd_t in_cmd,
  input  wire logic advance,
  output logic      cmd_vld,
  output cmd_t      cmd
);

  logic vld_r, vld_nxt;
  cmd_t cmd_r;

  assign in_ready = !vld_r || advance;
  assign cmd_vld  = vld_r;
  assign cmd      = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
    end
  end

endmodule
`default_nettype wire

/* sv/bsc_exec.sv */
`default_nettype none
module bsc_exec
  import bsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_vld,
  input  wire cmd_t cmd,
  output logic      advance,
  output logic      out_valid,
  input  wire logic out_ready,
  output rslt_t     rslt
);

  logic       en_r, en_nxt;
  logic [6:0] bright_r, bright_nxt;
  rgb_t       on_r, on_nxt;
  rgb_t       off_r, off_nxt;
  logic       out_vld_r, out_vld_nxt;
  rslt_t      rslt_r, rslt_nxt;
  logic       defined;

  assign advance   = cmd_vld && (!out_vld_r || out_ready);
  assign out_valid = out_vld_r;
  assign rslt      = rslt_r;

  always_comb begin
    en_nxt     = en_r;
    bright_nxt = bright_r;
    on_nxt     = on_r;
    off_nxt    = off_r;
    defined    = 1'b1;
    rslt_nxt.update_type  = UPD_COLOR;
    rslt_nxt.update_param = '0;
    rslt_nxt.update_mask  = 1'b0;
    case (op_t'(cmd.opcode))
      OP_SET_EN: begin
        en_nxt = cmd.enable_in;
        rslt_nxt.update_type  = UPD_ONOFF;
        rslt_nxt.update_param = {7'd0, cmd.enable_in};
      end
      OP_SET_BRIGHT: begin
        if (cmd.brightness_in > {1'b0, BRIGHT_MAX}) begin
          bright_nxt = BRIGHT_MAX;
        end else begin
          bright_nxt = cmd.brightness_in[6:0];
        end
        rslt_nxt.update_type  = UPD_BRIGHT;
        rslt_nxt.update_param = {1'b0, bright_nxt};
      end
      OP_SET_ON: begin
        on_nxt = cmd.color_in;
      end
      OP_SET_OFF: begin
        off_nxt = cmd.color_in;
      end
      OP_TOGGLE: begin
        en_nxt = !en_r;
        rslt_nxt.update_type  = UPD_ONOFF;
        rslt_nxt.update_param = {7'd0, !en_r};
      end
      OP_INC: begin
        if (bright_r <= BRIGHT_STEP_TOP) begin
          bright_nxt = bright_r + BRIGHT_STEP;
        end else begin
          bright_nxt = BRIGHT_MAX;
        end
        rslt_nxt.update_type  = UPD_BRIGHT;
        rslt_nxt.update_param = {1'b0, bright_nxt};
      end
      OP_DEC: begin
        if (bright_r >= BRIGHT_STEP_LOW) begin
          bright_nxt = bright_r - BRIGHT_STEP;
        end else begin
          bright_nxt = BRIGHT_FLOOR;
        end
        rslt_nxt.update_type  = UPD_BRIGHT;
        rslt_nxt.update_param = {1'b0, bright_nxt};
      end
      OP_CYC_ON: begin
        on_nxt = on_advance(on_r);
      end
      OP_CYC_OFF: begin
        off_nxt = off_advance(off_r);
      end
      OP_SWITCH: begin
        rslt_nxt.update_type  = UPD_SWITCH;
        rslt_nxt.update_param = cmd.switch_index;
        rslt_nxt.update_mask  = cmd.switch_on;
      end
      OP_WIFI: begin
        rslt_nxt.update_type  = UPD_WIFI;
        rslt_nxt.update_param = cmd.wifi_pattern;
      end
      OP_REFRESH: begin
      end
      default: begin
        // Unused opcodes leave the settings alone and produce no word.
        defined    = 1'b0;
        en_nxt     = en_r;
        bright_nxt = bright_r;
        on_nxt     = on_r;
        off_nxt    = off_r;
      end
    endcase
    rslt_nxt.enabled_now    = en_nxt;
    rslt_nxt.brightness_now = bright_nxt;
    rslt_nxt.on_rgb         = on_nxt;
    rslt_nxt.off_rgb        = off_nxt;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = defined;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= 1'b1;
      bright_r  <= BRIGHT_MAX;
      on_r      <= ON_RESET;
      off_r     <= OFF_RESET;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        en_r     <= en_nxt;
        bright_r <= bright_nxt;
        on_r     <= on_nxt;
        off_r    <= off_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rslt_r <= rslt_nxt;
    end
  end

  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    bright_r <= BRIGHT_MAX)
    else $error("brightness setting above maximum");

  a_undef_silent: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !defined |=> !out_vld_r)
    else $error("unused opcode produced a word");

  a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd.opcode == OP_TOGGLE |=> en_r != $past(en_r))
    else $error("toggle did not change the enable");

  a_bright_msg: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && rslt_r.update_type == UPD_BRIGHT |->
      rslt_r.update_param == {1'b0, rslt_r.brightness_now})
    else $error("brightness word disagrees with setting");

endmodule
`default_nettype wire

/* sv/backlight_settings_controller_core.sv */
// A command word accepted at the input handshake is held in the input register, then its
// result word is written to the result register, from which it can be taken.
// Throughput: one command word per cycle while out_tready accepts results; the input register
// can take a new word while a finished result waits, and the settings update in the output stage.
// Unused opcodes pass through without a result word.
// Reset (rst_n low, synchronous): both stages empty, enable on, brightness 100,
// on color blue, off color mid gray.
`default_nettype none
module backlight_settings_controller_core
  import bsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // enable_in[0], brightness_in[8:1], red_in[16:9], green_in[24:17], blue_in[32:25],
  // switch_index[40:33], switch_on[41], wifi_pattern[49:42], zeros above
  input  wire logic [55:0] in_tdata,
  // opcode[3:0]
  input  wire logic [3:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // update_param[7:0], update_mask[8], enabled_now[9], brightness_now[16:10],
  // on_red[24:17], on_green[32:25], on_blue[40:33], off_red[48:41],
  // off_green[56:49], off_blue[64:57], zeros above
  output logic [71:0]      out_tdata,
  // update_type[2:0]
  output logic [2:0]       out_tuser
);

  cmd_t  in_cmd;
  cmd_t  cmd;
  logic  cmd_vld;
  logic  advance;
  rslt_t rslt;

  assign in_cmd.opcode         = in_tuser;
  assign in_cmd.enable_in      = in_tdata[0];
  assign in_cmd.brightness_in  = in_tdata[8:1];
  assign in_cmd.color_in.red   = in_tdata[16:9];
  assign in_cmd.color_in.green = in_tdata[24:17];
  assign in_cmd.color_in.blue  = in_tdata[32:25];
  assign in_cmd.switch_index   = in_tdata[40:33];
  assign in_cmd.switch_on      = in_tdata[41];
  assign in_cmd.wifi_pattern   = in_tdata[49:42];

  bsc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_cmd),
    .advance  (advance),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd)
  );

  bsc_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_vld   (cmd_vld),
    .cmd       (cmd),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .rslt      (rslt)
  );

  assign out_tuser = rslt.update_type;
  assign out_tdata = {7'd0,
                      rslt.off_rgb.blue, rslt.off_rgb.green, rslt.off_rgb.red,
                      rslt.on_rgb.blue, rslt.on_rgb.green, rslt.on_rgb.red,
                      rslt.brightness_now, rslt.enabled_now, rslt.update_mask,
                      rslt.update_param};

endmodule
`default_nettype wire
